// ----- rtl/pom_pkg.sv -----
// Shared constants, types and tables of the perturb-and-observe tracker.
`timescale 1ns / 1ps
package pom_pkg;

   localparam int SampleBits = 12;
   localparam int LogDepth = 64;
   localparam int LogIdxBits = $clog2(LogDepth);
   localparam int AvgBits = SampleBits + 16;
   localparam int PwrBits = 2 * SampleBits + 16;
   localparam int MulBits = PwrBits > AvgBits ? PwrBits : AvgBits;
   localparam logic [15:0] Ln2Q16 = 16'd45426;

   localparam logic [2:0] CSR_FILTER_LEN = 3'd0;
   localparam logic [2:0] CSR_ADAPTIVE_ON = 3'd1;
   localparam logic [2:0] CSR_FIXED_STEP = 3'd2;
   localparam logic [2:0] CSR_MIN_STEP = 3'd3;
   localparam logic [2:0] CSR_MAX_STEP = 3'd4;
   localparam logic [2:0] CSR_LOG_GAIN = 3'd5;
   localparam logic [2:0] CSR_DUTY_LOW = 3'd6;
   localparam logic [2:0] CSR_DUTY_HIGH = 3'd7;

   // multiplier operand selects
   localparam logic [2:0] MUL_VOLT = 3'd0;
   localparam logic [2:0] MUL_AMP = 3'd1;
   localparam logic [2:0] MUL_PROD = 3'd2;
   localparam logic [2:0] MUL_PWR = 3'd3;
   localparam logic [2:0] MUL_LN = 3'd4;
   localparam logic [2:0] MUL_GAIN = 3'd5;

   typedef struct packed {
      logic load;
      logic mul_go;
      logic [2:0] mul_sel;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic mul_done;
   } stat_type;

   // log2(1+k/LogDepth) in Q0.16, truncated
   function automatic logic [15:0] log2_frac(input int k);
      logic [63:0] x;
      logic [15:0] res;
      x = ((64'(LogDepth) + 64'(k)) << 30) / 64'(LogDepth);
      res = '0;
      for (int b = 15; b >= 0; b--) begin
         x = (x * x) >> 30;
         if (x >= (64'd2 << 30)) begin
            x = x >> 1;
            res[b] = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic logic [15:0] log_rom(input logic [LogIdxBits-1:0] idx);
      logic [15:0] tbl [LogDepth];
      for (int k = 0; k < LogDepth; k++) tbl[k] = log2_frac(k);
      return tbl[idx];
   endfunction

endpackage

// ----- rtl/pom_mul.sv -----
// Multi-cycle shift-add multiplier, 4 bits of the multiplier per cycle.
`timescale 1ns / 1ps
module pom_mul (
   input  logic clock,
   input  logic reset,
   input  logic go,
   input  logic [pom_pkg::MulBits-1:0] a,
   input  logic [16:0] b,
   output logic done,
   output logic [pom_pkg::MulBits+16:0] prod
);
   localparam int PW = pom_pkg::MulBits + 17;
   logic [PW-1:0] acc_ff, acc_in;
   logic [PW-1:0] a_ff, a_in;
   logic [16:0] b_ff, b_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;

   always_comb begin
      acc_in = acc_ff;
      a_in = a_ff;
      b_in = b_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (go) begin
         acc_in = '0;
         a_in = PW'(a);
         b_in = b;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + a_ff * PW'(b_ff[3:0]);
         a_in = a_ff << 4;
         b_in = b_ff >> 4;
         if (b_ff[16:4] == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule

// ----- rtl/pom_ctrl.sv -----
// Sequencer that steps the datapath through one sample.
`timescale 1ns / 1ps
module pom_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  pom_pkg::stat_type stat,
   output pom_pkg::cmd_type cmd
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_VGO = 4'd1;
   localparam logic [3:0] S_VW = 4'd2;
   localparam logic [3:0] S_AGO = 4'd3;
   localparam logic [3:0] S_AW = 4'd4;
   localparam logic [3:0] S_PGO = 4'd5;
   localparam logic [3:0] S_PW = 4'd6;
   localparam logic [3:0] S_FGO = 4'd7;
   localparam logic [3:0] S_FW = 4'd8;
   localparam logic [3:0] S_LGO = 4'd9;
   localparam logic [3:0] S_LW = 4'd10;
   localparam logic [3:0] S_GGO = 4'd11;
   localparam logic [3:0] S_GW = 4'd12;
   localparam logic [3:0] S_FIN = 4'd13;
   localparam logic [3:0] S_DW = 4'd14;

   logic [3:0] state_ff, state_in;
   logic out_ff, out_in;

   assign req_ready = (state_ff == S_IDLE) && !out_ff;
   assign rsp_valid = out_ff;

   always_comb begin
      state_in = state_ff;
      out_in = out_ff && !rsp_ready;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = S_DW;
            end
         end
         S_DW: begin
            // wait for the filter weight
            if (stat.div_done) state_in = S_VGO;
         end
         S_VGO, S_AGO, S_PGO, S_FGO, S_LGO, S_GGO: begin
            cmd.mul_go = 1'b1;
            state_in = state_ff + 4'd1;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            out_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            if (stat.mul_done) state_in = state_ff + 4'd1;
         end
      endcase
      case (state_ff)
         S_VGO, S_VW: cmd.mul_sel = pom_pkg::MUL_VOLT;
         S_AGO, S_AW: cmd.mul_sel = pom_pkg::MUL_AMP;
         S_PGO, S_PW: cmd.mul_sel = pom_pkg::MUL_PROD;
         S_FGO, S_FW: cmd.mul_sel = pom_pkg::MUL_PWR;
         S_LGO, S_LW: cmd.mul_sel = pom_pkg::MUL_LN;
         default: cmd.mul_sel = pom_pkg::MUL_GAIN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff <= out_in;
      end
   end
endmodule

// ----- rtl/pom_dp.sv -----
// Datapath: filters, power, log step, direction and duty.
`timescale 1ns / 1ps
module pom_dp (
   input  logic clock,
   input  logic reset,
   input  pom_pkg::cmd_type cmd,
   output pom_pkg::stat_type stat,
   input  logic [pom_pkg::SampleBits-1:0] volt_sample,
   input  logic [pom_pkg::SampleBits-1:0] amp_sample,
   input  logic csr_write,
   input  logic [2:0] csr_index,
   input  logic [15:0] csr_data,
   output logic [15:0] duty_out
);
   localparam int AB = pom_pkg::AvgBits;
   localparam int PB = pom_pkg::PwrBits;
   localparam int MB = pom_pkg::MulBits;
   localparam int XB = PB + 1;

   logic [8:0] filt_len_ff;
   logic adapt_ff;
   logic [15:0] fix_step_ff, min_step_ff, max_step_ff, gain_ff, dlo_ff, dhi_ff;

   logic [AB-1:0] vavg_ff, aavg_ff, vx_ff, ax_ff;
   logic [PB-1:0] pavg_ff, plast_ff, prod_ff;
   logic [15:0] duty_ff;
   logic dir_ff;
   logic [XB-1:0] lnq_ff;
   logic [31:0] step_add_ff;

   logic [MB-1:0] mul_a;
   logic [16:0] mul_b;
   logic mul_done;
   logic [MB+16:0] mul_p;

   pom_mul u_mul (
      .clock(clock), .reset(reset), .go(cmd.mul_go), .a(mul_a), .b(mul_b),
      .done(mul_done), .prod(mul_p)
   );

   // restoring divider for the filter weight floor(65536/n), one bit per cycle
   logic [8:0] div_rem_ff, div_rem_in;
   logic [15:0] div_q_ff, div_q_in;
   logic [4:0] div_cnt_ff, div_cnt_in;
   logic div_busy_ff, div_busy_in;
   logic div_done_ff, div_done_in;
   logic [9:0] div_try;
   logic [15:0] recip;

   always_comb begin
      div_rem_in = div_rem_ff;
      div_q_in = div_q_ff;
      div_cnt_in = div_cnt_ff;
      div_busy_in = div_busy_ff;
      div_done_in = 1'b0;
      div_try = {div_rem_ff, div_cnt_ff == 5'd16};
      if (cmd.load) begin
         div_rem_in = '0;
         div_q_in = '0;
         div_cnt_in = 5'd16;
         div_busy_in = 1'b1;
      end else if (div_busy_ff) begin
         if (div_try >= {1'b0, filt_len_ff}) begin
            div_rem_in = 9'(div_try - {1'b0, filt_len_ff});
            div_q_in = {div_q_ff[14:0], 1'b1};
         end else begin
            div_rem_in = div_try[8:0];
            div_q_in = {div_q_ff[14:0], 1'b0};
         end
         div_cnt_in = div_cnt_ff - 5'd1;
         if (div_cnt_ff == 5'd0) begin
            div_busy_in = 1'b0;
            div_done_in = 1'b1;
         end
      end
   end

   assign recip = div_q_ff;
   assign stat = '{div_done: div_done_ff, mul_done: mul_done};

   // differences for the three filters
   logic v_up, a_up, p_up;
   logic [AB-1:0] vdiff, adiff;
   logic [PB-1:0] pdiff;
   logic [PB-1:0] mag;
   logic bypass;
   assign bypass = (filt_len_ff <= 9'd1);
   assign v_up = vx_ff >= vavg_ff;
   assign a_up = ax_ff >= aavg_ff;
   assign p_up = prod_ff >= pavg_ff;
   assign vdiff = v_up ? vx_ff - vavg_ff : vavg_ff - vx_ff;
   assign adiff = a_up ? ax_ff - aavg_ff : aavg_ff - ax_ff;
   assign pdiff = p_up ? prod_ff - pavg_ff : pavg_ff - prod_ff;
   assign mag = (pavg_ff > plast_ff) ? pavg_ff - plast_ff : plast_ff - pavg_ff;

   // leading-one search of |dP|+1 (narrow priority encoder)
   logic [XB-1:0] m;
   logic [6:0] e;
   logic [XB-1:0] f;
   logic [pom_pkg::LogIdxBits-1:0] idx;
   logic [XB+pom_pkg::LogIdxBits-1:0] fsh;
   assign m = XB'(mag) + XB'(65536);
   always_comb begin
      e = 7'd16;
      for (int i = 17; i < XB; i++) if (m[i]) e = 7'(i);
   end
   assign f = m - (XB'(1) << e);
   assign fsh = ({f, {pom_pkg::LogIdxBits{1'b0}}}) >> e;
   assign idx = fsh[pom_pkg::LogIdxBits-1:0];
   logic [XB-1:0] l2;
   assign l2 = (XB'(e - 7'd16) << 16) + XB'(pom_pkg::log_rom(idx));

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         pom_pkg::MUL_VOLT: begin mul_a = MB'(vdiff); mul_b = {1'b0, recip}; end
         pom_pkg::MUL_AMP: begin mul_a = MB'(adiff); mul_b = {1'b0, recip}; end
         pom_pkg::MUL_PROD: begin mul_a = MB'(vavg_ff); mul_b = 17'(aavg_ff[15:0]); end
         pom_pkg::MUL_PWR: begin mul_a = MB'(pdiff); mul_b = {1'b0, recip}; end
         pom_pkg::MUL_LN: begin mul_a = MB'(l2); mul_b = {1'b0, pom_pkg::Ln2Q16}; end
         default: begin mul_a = MB'(lnq_ff); mul_b = {1'b0, gain_ff}; end
      endcase
   end

   // high half of volt*amp handled by a second narrow product
   logic [AB+16-1:0] hi_part;
   assign hi_part = (AB+16)'(vavg_ff) * (AB+16)'(aavg_ff[AB-1:16]);

   function automatic logic [MB+16:0] filt_delta(input logic up, input logic [MB+16:0] p);
      logic [MB+16:0] r;
      r = up ? (p >> 16) : ((p + (MB+17)'(65535)) >> 16);
      return r;
   endfunction

   // step and duty
   logic [32:0] step_sum;
   logic [16:0] step;
   logic rising, dir_new;
   logic signed [18:0] duty_calc;
   always_comb begin
      rising = pavg_ff > plast_ff;
      step_sum = 33'(min_step_ff) + 33'(step_add_ff);
      if (!adapt_ff) step = {1'b0, fix_step_ff};
      else if (step_sum < 33'(min_step_ff)) step = {1'b0, min_step_ff};
      else if (step_sum > 33'(max_step_ff)) step = {1'b0, max_step_ff};
      else step = step_sum[16:0];
      dir_new = dir_ff ^ !rising;
      duty_calc = dir_new ? 19'(duty_ff) - 19'(step) : 19'(duty_ff) + 19'(step);
      if (duty_calc < $signed(19'(dlo_ff))) duty_calc = 19'(dlo_ff);
      else if (duty_calc > $signed(19'(dhi_ff))) duty_calc = 19'(dhi_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_len_ff <= 9'd1; adapt_ff <= 1'b0; fix_step_ff <= 16'd256;
         min_step_ff <= 16'd64; max_step_ff <= 16'd2048; gain_ff <= 16'd256;
         dlo_ff <= 16'd0; dhi_ff <= 16'hFFFF;
         vavg_ff <= '0; aavg_ff <= '0; pavg_ff <= '0; plast_ff <= '0;
         duty_ff <= 16'd32768; dir_ff <= 1'b0;
         div_busy_ff <= 1'b0; div_done_ff <= 1'b0;
      end else begin
         div_busy_ff <= div_busy_in;
         div_done_ff <= div_done_in;
         if (csr_write) begin
            case (csr_index)
               pom_pkg::CSR_FILTER_LEN: filt_len_ff <= csr_data[8:0];
               pom_pkg::CSR_ADAPTIVE_ON: adapt_ff <= csr_data[0];
               pom_pkg::CSR_FIXED_STEP: fix_step_ff <= csr_data;
               pom_pkg::CSR_MIN_STEP: min_step_ff <= csr_data;
               pom_pkg::CSR_MAX_STEP: max_step_ff <= csr_data;
               pom_pkg::CSR_LOG_GAIN: gain_ff <= csr_data;
               pom_pkg::CSR_DUTY_LOW: dlo_ff <= csr_data;
               default: dhi_ff <= csr_data;
            endcase
         end
         if (mul_done) begin
            case (cmd.mul_sel)
               pom_pkg::MUL_VOLT: begin
                  if (bypass) vavg_ff <= vx_ff;
                  else if (v_up) vavg_ff <= vavg_ff + AB'(filt_delta(1'b1, mul_p));
                  else vavg_ff <= vavg_ff - AB'(filt_delta(1'b0, mul_p));
               end
               pom_pkg::MUL_AMP: begin
                  if (bypass) aavg_ff <= ax_ff;
                  else if (a_up) aavg_ff <= aavg_ff + AB'(filt_delta(1'b1, mul_p));
                  else aavg_ff <= aavg_ff - AB'(filt_delta(1'b0, mul_p));
               end
               pom_pkg::MUL_PWR: begin
                  if (bypass) pavg_ff <= prod_ff;
                  else if (p_up) pavg_ff <= pavg_ff + PB'(filt_delta(1'b1, mul_p));
                  else pavg_ff <= pavg_ff - PB'(filt_delta(1'b0, mul_p));
               end
               default: ;
            endcase
         end
         if (cmd.finish) begin
            plast_ff <= pavg_ff;
            dir_ff <= dir_new;
            duty_ff <= duty_calc[15:0];
         end
      end
      div_rem_ff <= div_rem_in;
      div_q_ff <= div_q_in;
      div_cnt_ff <= div_cnt_in;
      if (cmd.load) begin
         vx_ff <= {volt_sample, 16'd0};
         ax_ff <= {amp_sample, 16'd0};
      end
      if (mul_done) begin
         case (cmd.mul_sel)
            pom_pkg::MUL_PROD:
               prod_ff <= PB'((mul_p[AB+15:16]) + PB'(hi_part));
            pom_pkg::MUL_LN: lnq_ff <= XB'(mul_p >> 16);
            pom_pkg::MUL_GAIN: step_add_ff <= 32'(mul_p >> 24);
            default: ;
         endcase
      end
   end

   assign duty_out = duty_ff;
endmodule

// ----- rtl/perturb_observe_mppt_top.sv -----
// Top level of the perturb-and-observe maximum power point tracker.
`timescale 1ns / 1ps
// Usage:
//   Input channel req_*: one voltage/current sample pair per transfer.
//   Result channel rsp_*: one duty value per accepted sample, in order.
//   csr_*: write-only register port, index 0..7 as filter length, adaptive
//   enable, fixed step, min/max step, log gain, duty low/high. Write only
//   while the block is idle.
//   Sequence from the sample transfer to rsp_valid: the filter weight
//   65536/n comes from a bit-serial divider, then six passes run through
//   one shared 4-bit-per-cycle multiplier (filters, power product, log
//   scaling, gain), each a start state and a wait for the multiplier done;
//   a final state updates the duty and raises rsp_valid. A new sample is
//   not taken before the last result is through: req_ready drops from the
//   transfer until the result has been taken.
//   When the receiver stalls, hold the duty in the output register; no new
//   sample is taken until that transfer completes.
//   Reset (synchronous, active high) clears filter state, power history
//   and direction, sets duty to mid-scale and loads register defaults.
module perturb_observe_mppt_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [pom_pkg::SampleBits-1:0] req_volt_sample,
   input  logic [pom_pkg::SampleBits-1:0] req_amp_sample,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [15:0] rsp_duty_out,
   input  logic csr_write,
   input  logic [2:0] csr_index,
   input  logic [15:0] csr_data
);
   pom_pkg::cmd_type cmd;
   pom_pkg::stat_type stat;

   pom_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .stat(stat), .cmd(cmd)
   );

   pom_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .volt_sample(req_volt_sample), .amp_sample(req_amp_sample),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .duty_out(rsp_duty_out)
   );

   // no new sample while a result is pending
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("sample taken while result pending");
   // result stays until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duty_out))
      else $error("result dropped");
   // load and finish never together
   assert property (@(posedge clock) disable iff (reset) !(cmd.load && cmd.finish))
      else $error("load and finish overlap");
endmodule
